// ----- src/tlu_pkg.sv -----
package tlu_pkg;

  // Coefficient entries per layer: a,b,c,d for each of the main, upper and lower diagonals.
  localparam int SETS = 12;
  localparam int COEFS_PER_SET = 4;
  localparam int CORDIC_STEPS = 28;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;
  localparam int LAYER_W = 6;

  // Configuration register indexes.
  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;

  // Datapath operations.
  localparam logic [4:0] OP_NONE         = 5'd0;
  localparam logic [4:0] OP_LOAD         = 5'd1;
  localparam logic [4:0] OP_CAPTURE      = 5'd2;
  localparam logic [4:0] OP_ANG_START    = 5'd3;
  localparam logic [4:0] OP_DIV_STEP     = 5'd4;
  localparam logic [4:0] OP_CORDIC_INIT  = 5'd5;
  localparam logic [4:0] OP_CORDIC_STEP  = 5'd6;
  localparam logic [4:0] OP_CORDIC_END   = 5'd7;
  localparam logic [4:0] OP_MUL_E        = 5'd8;
  localparam logic [4:0] OP_EXY          = 5'd9;
  localparam logic [4:0] OP_LAYER_START  = 5'd10;
  localparam logic [4:0] OP_ACC_CLR      = 5'd11;
  localparam logic [4:0] OP_READ         = 5'd12;
  localparam logic [4:0] OP_MUL_COEF     = 5'd13;
  localparam logic [4:0] OP_ACC_PROD     = 5'd14;
  localparam logic [4:0] OP_ACC_D        = 5'd15;
  localparam logic [4:0] OP_SET_V        = 5'd16;
  localparam logic [4:0] OP_MUL_LA       = 5'd17;
  localparam logic [4:0] OP_L_RE         = 5'd18;
  localparam logic [4:0] OP_MUL_LB       = 5'd19;
  localparam logic [4:0] OP_L_IM         = 5'd20;
  localparam logic [4:0] OP_MUL_DA       = 5'd21;
  localparam logic [4:0] OP_DEN_RE       = 5'd22;
  localparam logic [4:0] OP_MUL_DB       = 5'd23;
  localparam logic [4:0] OP_DEN_IM       = 5'd24;
  localparam logic [4:0] OP_DEN_D        = 5'd25;
  localparam logic [4:0] OP_MUL_N        = 5'd26;
  localparam logic [4:0] OP_NORM         = 5'd27;
  localparam logic [4:0] OP_RECIP_START  = 5'd28;
  localparam logic [4:0] OP_RECIP_END    = 5'd29;
  localparam logic [4:0] OP_EMIT         = 5'd30;

  // Coefficient set selectors.
  localparam logic [1:0] SET_MAIN  = 2'd0;
  localparam logic [1:0] SET_UPPER = 2'd1;
  localparam logic [1:0] SET_LOWER = 2'd2;

  typedef struct packed {
    logic [4:0]         op;
    logic               axis;
    logic [4:0]         idx;
    logic [1:0]         set;
    logic [LAYER_W-1:0] layer;
    logic               first;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic norm_zero;
  } stat_t;

  function automatic logic [31:0] cordic_angle(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd268435456;
      5'd1:  r = 32'd158466703;
      5'd2:  r = 32'd83729454;
      5'd3:  r = 32'd42502378;
      5'd4:  r = 32'd21333666;
      5'd5:  r = 32'd10677233;
      5'd6:  r = 32'd5339919;
      5'd7:  r = 32'd2670123;
      5'd8:  r = 32'd1335082;
      5'd9:  r = 32'd667543;
      5'd10: r = 32'd333772;
      5'd11: r = 32'd166886;
      5'd12: r = 32'd83443;
      5'd13: r = 32'd41722;
      5'd14: r = 32'd20861;
      5'd15: r = 32'd10430;
      5'd16: r = 32'd5215;
      5'd17: r = 32'd2608;
      5'd18: r = 32'd1304;
      5'd19: r = 32'd652;
      5'd20: r = 32'd326;
      5'd21: r = 32'd163;
      5'd22: r = 32'd81;
      5'd23: r = 32'd41;
      5'd24: r = 32'd20;
      5'd25: r = 32'd10;
      5'd26: r = 32'd5;
      5'd27: r = 32'd3;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic ovf32(input logic signed [65:0] v);
    return (v > 66'sd2147483647) || (v < -66'sd2147483648);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- src/tlu_item_if.sv -----
interface tlu_item_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [5:0]         layer;
  logic [3:0]         coef_sel;
  logic signed [31:0] value_re;
  logic signed [31:0] value_im;
  logic [11:0]        col_x;
  logic [11:0]        col_y;

  modport source (output valid, mode, layer, coef_sel, value_re, value_im, col_x, col_y,
                  input ready);
  modport sink (input valid, mode, layer, coef_sel, value_re, value_im, col_x, col_y,
                output ready);
endinterface

// ----- src/tlu_result_if.sv -----
interface tlu_result_if;
  logic               valid;
  logic               ready;
  logic [5:0]         out_layer;
  logic signed [31:0] lower_re;
  logic signed [31:0] lower_im;
  logic signed [31:0] inv_pivot_re;
  logic signed [31:0] inv_pivot_im;
  logic signed [31:0] upper_re;
  logic signed [31:0] upper_im;
  logic               saturated;
  logic               last;

  modport source (output valid, out_layer, lower_re, lower_im, inv_pivot_re, inv_pivot_im,
                  upper_re, upper_im, saturated, last, input ready);
  modport sink (input valid, out_layer, lower_re, lower_im, inv_pivot_re, inv_pivot_im,
                upper_re, upper_im, saturated, last, output ready);
endinterface

// ----- src/tlu_datapath.sv -----
module tlu_datapath #(
  parameter int LAYERS_MAX = 64,
  parameter int FRAC_BITS  = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  tlu_pkg::cmd_t      cmd,
  output tlu_pkg::stat_t     stat,
  input  logic [12:0]        size_x,
  input  logic [12:0]        size_y,
  input  logic [5:0]         ld_layer,
  input  logic [3:0]         ld_sel,
  input  logic signed [31:0] ld_re,
  input  logic signed [31:0] ld_im,
  input  logic [11:0]        col_x,
  input  logic [11:0]        col_y,
  tlu_result_if.source       result
);

  localparam int DIVW   = 32 + 2 * FRAC_BITS;
  localparam int DEPTH  = LAYERS_MAX * tlu_pkg::SETS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CSH    = (FRAC_BITS < 29) ? 29 - FRAC_BITS : 1;
  localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

  logic [63:0] mem [DEPTH];
  logic [63:0] rd;

  logic [11:0]        cx_idx, cy_idx;
  logic signed [31:0] ex, ey, exy;
  logic               gsat, flag;
  logic signed [31:0] dv_re, dv_im, pv_re, pv_im, mv_re, mv_im;
  logic signed [31:0] up_re, up_im, u_re, u_im, l_re, l_im, den_re, den_im;
  logic signed [63:0] p0, p1;
  logic signed [65:0] acc_re, acc_im;
  logic [63:0]        n;
  logic [DIVW-1:0]    dvd [2];
  logic [63:0]        rem [2];
  logic [31:0]        quo [2];
  logic               big [2];
  logic               qneg [2];
  logic signed [33:0] cx, cy;
  logic signed [31:0] cz;
  logic               cneg;

  // Address generation and load range check.
  logic              ld_ok;
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  always_comb begin
    ld_ok   = ({1'b0, ld_layer} < 7'(LAYERS_MAX)) && (ld_sel < 4'(tlu_pkg::SETS));
    wr_addr = ADDR_W'(int'(ld_layer) * tlu_pkg::SETS + int'(ld_sel));
    rd_addr = ADDR_W'(int'(cmd.layer) * tlu_pkg::SETS
                      + int'(cmd.set) * tlu_pkg::COEFS_PER_SET + int'(cmd.idx[1:0]));
  end

  always_ff @(posedge clk) begin
    if (cmd.op == tlu_pkg::OP_LOAD && ld_ok) begin
      mem[wr_addr] <= {ld_im, ld_re};
    end
    if (cmd.op == tlu_pkg::OP_READ) begin
      rd <= mem[rd_addr];
    end
  end

  // Multiplier operand selection.
  logic signed [31:0] ma0, mb0, ma1, mb1, esel;
  logic               is_mul;

  always_comb begin
    ma0 = '0;
    mb0 = '0;
    ma1 = '0;
    mb1 = '0;
    is_mul = 1'b1;
    case (cmd.idx[1:0])
      2'd0:    esel = exy;
      2'd1:    esel = ex;
      default: esel = ey;
    endcase
    case (cmd.op)
      tlu_pkg::OP_MUL_COEF: begin
        ma0 = rd[31:0];
        mb0 = esel;
        ma1 = rd[63:32];
        mb1 = esel;
      end
      tlu_pkg::OP_MUL_E: begin
        ma0 = ex;
        mb0 = ey;
      end
      tlu_pkg::OP_MUL_LA: begin
        ma0 = mv_re;
        mb0 = u_re;
        ma1 = mv_im;
        mb1 = u_im;
      end
      tlu_pkg::OP_MUL_LB: begin
        ma0 = mv_re;
        mb0 = u_im;
        ma1 = mv_im;
        mb1 = u_re;
      end
      tlu_pkg::OP_MUL_DA: begin
        ma0 = up_re;
        mb0 = l_re;
        ma1 = up_im;
        mb1 = l_im;
      end
      tlu_pkg::OP_MUL_DB: begin
        ma0 = up_re;
        mb0 = l_im;
        ma1 = up_im;
        mb1 = l_re;
      end
      tlu_pkg::OP_MUL_N: begin
        ma0 = den_re;
        mb0 = den_re;
        ma1 = den_im;
        mb1 = den_im;
      end
      default: is_mul = 1'b0;
    endcase
  end

  // Rounded products and their combinations.
  logic signed [65:0] rnd0, rnd1, pdiff, psum, acc_re_v, acc_im_v;
  logic signed [65:0] den_re_v, den_im_v;

  always_comb begin
    rnd0     = (66'(p0) + HALF) >>> FRAC_BITS;
    rnd1     = (66'(p1) + HALF) >>> FRAC_BITS;
    pdiff    = rnd0 - rnd1;
    psum     = rnd0 + rnd1;
    den_re_v = 66'(dv_re) - pdiff;
    den_im_v = 66'(dv_im) - psum;
    acc_re_v = acc_re;
    acc_im_v = acc_im;
  end

  // Restoring division, one quotient bit per lane per cycle.
  logic [64:0] remn [2];
  logic [63:0] rem_nx [2];
  logic        qbit [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      remn[l]   = {rem[l], dvd[l][DIVW-1]};
      qbit[l]   = remn[l] >= {1'b0, n};
      rem_nx[l] = qbit[l] ? 64'(remn[l] - {1'b0, n}) : remn[l][63:0];
    end
  end

  // Quotient signing and saturation of the reciprocal parts.
  logic signed [31:0] qres [2];
  logic               qovf [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      qovf[l] = 1'b0;
      if (qneg[l]) begin
        if (big[l] || quo[l] > 32'h80000000) begin
          qres[l] = 32'sh80000000;
          qovf[l] = 1'b1;
        end else begin
          qres[l] = -$signed(quo[l]);
        end
      end else if (big[l] || quo[l][31]) begin
        qres[l] = 32'sh7fffffff;
        qovf[l] = 1'b1;
      end else begin
        qres[l] = $signed(quo[l]);
      end
    end
  end

  // Angle folding into the first quadrant.
  logic [30:0] a0, a1, a2;
  logic        fneg;

  always_comb begin
    a0   = quo[0][30:0];
    a1   = (a0 > 31'd1073741824) ? 31'(31'd0 - a0) : a0;
    fneg = a1 > 31'd536870912;
    a2   = fneg ? 31'(31'd1073741824 - a1) : a1;
  end

  // CORDIC rotation and output scaling.
  logic signed [33:0] dx, dy;
  logic signed [31:0] cang;
  logic signed [35:0] cv, cvn;
  logic signed [65:0] cvx;

  always_comb begin
    dx   = cy >>> cmd.idx;
    dy   = cx >>> cmd.idx;
    cang = $signed(tlu_pkg::cordic_angle(cmd.idx));
    if (FRAC_BITS == 30) begin
      cv = 36'(cx) <<< 1;
    end else if (FRAC_BITS == 29) begin
      cv = 36'(cx);
    end else begin
      cv = (36'(cx) + (36'sd1 <<< (CSH - 1))) >>> CSH;
    end
    cvn = cneg ? -cv : cv;
    cvx = 66'(cvn);
  end

  // Reciprocal operands.
  logic [31:0] mag0, mag1;

  always_comb begin
    mag0 = den_re[31] ? 32'(-den_re) : den_re;
    mag1 = den_im[31] ? 32'(-den_im) : den_im;
  end

  always_ff @(posedge clk) begin
    if (is_mul) begin
      p0 <= ma0 * mb0;
      p1 <= ma1 * mb1;
    end
    case (cmd.op)
      tlu_pkg::OP_CAPTURE: begin
        cx_idx <= col_x;
        cy_idx <= col_y;
        gsat   <= 1'b0;
      end
      tlu_pkg::OP_ANG_START: begin
        dvd[0] <= DIVW'({(cmd.axis ? 13'(cy_idx) : 13'(cx_idx)) + 13'd1, 30'd0});
        n      <= 64'((cmd.axis ? 14'(size_y) : 14'(size_x)) + 14'd1);
        rem[0] <= '0;
        quo[0] <= '0;
        big[0] <= 1'b0;
      end
      tlu_pkg::OP_DIV_STEP: begin
        for (int l = 0; l < 2; l++) begin
          dvd[l] <= dvd[l] << 1;
          rem[l] <= rem_nx[l];
          quo[l] <= {quo[l][30:0], qbit[l]};
          big[l] <= big[l] | quo[l][31];
        end
      end
      tlu_pkg::OP_CORDIC_INIT: begin
        cx   <= tlu_pkg::CORDIC_GAIN;
        cy   <= '0;
        cz   <= $signed({1'b0, a2});
        cneg <= fneg;
      end
      tlu_pkg::OP_CORDIC_STEP: begin
        if (!cz[31]) begin
          cx <= cx - dx;
          cy <= cy + dy;
          cz <= cz - cang;
        end else begin
          cx <= cx + dx;
          cy <= cy - dy;
          cz <= cz + cang;
        end
      end
      tlu_pkg::OP_CORDIC_END: begin
        if (cmd.axis) begin
          ey <= tlu_pkg::sat32(cvx);
        end else begin
          ex <= tlu_pkg::sat32(cvx);
        end
        gsat <= gsat | tlu_pkg::ovf32(cvx);
      end
      tlu_pkg::OP_EXY: begin
        exy  <= tlu_pkg::sat32(rnd0);
        gsat <= gsat | tlu_pkg::ovf32(rnd0);
      end
      tlu_pkg::OP_LAYER_START: begin
        flag <= gsat;
        if (cmd.first) begin
          l_re <= '0;
          l_im <= '0;
        end
      end
      tlu_pkg::OP_ACC_CLR: begin
        acc_re <= '0;
        acc_im <= '0;
      end
      tlu_pkg::OP_ACC_PROD: begin
        acc_re <= acc_re + rnd0;
        acc_im <= acc_im + rnd1;
      end
      tlu_pkg::OP_ACC_D: begin
        acc_re <= acc_re + 66'($signed(rd[31:0]));
        acc_im <= acc_im + 66'($signed(rd[63:32]));
      end
      tlu_pkg::OP_SET_V: begin
        case (cmd.set)
          tlu_pkg::SET_MAIN: begin
            dv_re <= tlu_pkg::sat32(acc_re_v);
            dv_im <= tlu_pkg::sat32(acc_im_v);
          end
          tlu_pkg::SET_UPPER: begin
            pv_re <= tlu_pkg::sat32(acc_re_v);
            pv_im <= tlu_pkg::sat32(acc_im_v);
          end
          default: begin
            mv_re <= tlu_pkg::sat32(acc_re_v);
            mv_im <= tlu_pkg::sat32(acc_im_v);
          end
        endcase
        flag <= flag | tlu_pkg::ovf32(acc_re_v) | tlu_pkg::ovf32(acc_im_v);
      end
      tlu_pkg::OP_L_RE: begin
        l_re <= tlu_pkg::sat32(pdiff);
        flag <= flag | tlu_pkg::ovf32(pdiff);
      end
      tlu_pkg::OP_L_IM: begin
        l_im <= tlu_pkg::sat32(psum);
        flag <= flag | tlu_pkg::ovf32(psum);
      end
      tlu_pkg::OP_DEN_RE: begin
        den_re <= tlu_pkg::sat32(den_re_v);
        flag   <= flag | tlu_pkg::ovf32(den_re_v);
      end
      tlu_pkg::OP_DEN_IM: begin
        den_im <= tlu_pkg::sat32(den_im_v);
        flag   <= flag | tlu_pkg::ovf32(den_im_v);
      end
      tlu_pkg::OP_DEN_D: begin
        den_re <= dv_re;
        den_im <= dv_im;
      end
      tlu_pkg::OP_NORM: begin
        n <= 64'(p0) + 64'(p1);
      end
      tlu_pkg::OP_RECIP_START: begin
        if (n == 64'd0) begin
          u_re <= 32'sh7fffffff;
          u_im <= '0;
          flag <= 1'b1;
        end
        dvd[0]  <= DIVW'(mag0) << (2 * FRAC_BITS);
        dvd[1]  <= DIVW'(mag1) << (2 * FRAC_BITS);
        qneg[0] <= den_re[31];
        qneg[1] <= !den_im[31] && (den_im != 32'sd0);
        for (int l = 0; l < 2; l++) begin
          rem[l] <= '0;
          quo[l] <= '0;
          big[l] <= 1'b0;
        end
      end
      tlu_pkg::OP_RECIP_END: begin
        u_re <= qres[0];
        u_im <= qres[1];
        flag <= flag | qovf[0] | qovf[1];
      end
      tlu_pkg::OP_EMIT: begin
        result.out_layer    <= cmd.layer;
        result.lower_re     <= l_re;
        result.lower_im     <= l_im;
        result.inv_pivot_re <= u_re;
        result.inv_pivot_im <= u_im;
        result.upper_re     <= pv_re;
        result.upper_im     <= pv_im;
        result.saturated    <= flag;
        result.last         <= cmd.last;
        up_re               <= pv_re;
        up_im               <= pv_im;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (cmd.op == tlu_pkg::OP_EMIT) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  assign stat.out_free  = !result.valid || result.ready;
  assign stat.norm_zero = (n == 64'd0);

endmodule

// ----- src/tlu_ctrl.sv -----
module tlu_ctrl #(
  parameter int LAYERS_MAX = 64,
  parameter int FRAC_BITS  = 24
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  logic           item_mode,
  output logic           item_ready,
  input  logic [6:0]     size_z,
  input  tlu_pkg::stat_t stat,
  output tlu_pkg::cmd_t  cmd
);

  localparam int DIVW  = 32 + 2 * FRAC_BITS;
  localparam int CNT_W = $clog2(DIVW);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_ANG    = 5'd1;
  localparam logic [4:0] S_ADIV   = 5'd2;
  localparam logic [4:0] S_CINIT  = 5'd3;
  localparam logic [4:0] S_CSTEP  = 5'd4;
  localparam logic [4:0] S_CEND   = 5'd5;
  localparam logic [4:0] S_MULE   = 5'd6;
  localparam logic [4:0] S_EXY    = 5'd7;
  localparam logic [4:0] S_LSTART = 5'd8;
  localparam logic [4:0] S_CLR    = 5'd9;
  localparam logic [4:0] S_RD     = 5'd10;
  localparam logic [4:0] S_MUL    = 5'd11;
  localparam logic [4:0] S_ACC    = 5'd12;
  localparam logic [4:0] S_ACCD   = 5'd13;
  localparam logic [4:0] S_SETV   = 5'd14;
  localparam logic [4:0] S_MLA    = 5'd15;
  localparam logic [4:0] S_LRE    = 5'd16;
  localparam logic [4:0] S_MLB    = 5'd17;
  localparam logic [4:0] S_LIM    = 5'd18;
  localparam logic [4:0] S_MDA    = 5'd19;
  localparam logic [4:0] S_DRE    = 5'd20;
  localparam logic [4:0] S_MDB    = 5'd21;
  localparam logic [4:0] S_DIM    = 5'd22;
  localparam logic [4:0] S_DEN0   = 5'd23;
  localparam logic [4:0] S_MULN   = 5'd24;
  localparam logic [4:0] S_NORM   = 5'd25;
  localparam logic [4:0] S_RSTART = 5'd26;
  localparam logic [4:0] S_RDIV   = 5'd27;
  localparam logic [4:0] S_REND   = 5'd28;
  localparam logic [4:0] S_EMIT   = 5'd29;

  logic [4:0]       state, state_next;
  logic             axis, axis_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [5:0]       k, k_next;
  logic [1:0]       s, s_next;
  logic [1:0]       j, j_next;
  logic [6:0]       nz;
  logic             last_layer;

  always_comb begin
    nz         = (size_z > 7'(LAYERS_MAX)) ? 7'(LAYERS_MAX) : size_z;
    last_layer = (7'(k) == nz - 7'd1);
  end

  always_comb begin
    state_next = state;
    axis_next  = axis;
    cnt_next   = cnt;
    k_next     = k;
    s_next     = s;
    j_next     = j;
    cmd        = '0;
    cmd.axis   = axis;
    cmd.idx    = 5'(cnt);
    cmd.set    = s;
    cmd.layer  = k;
    cmd.first  = (k == 6'd0);
    cmd.last   = last_layer;
    item_ready = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          if (!item_mode) begin
            cmd.op = tlu_pkg::OP_LOAD;
          end else if (nz != 7'd0) begin
            cmd.op     = tlu_pkg::OP_CAPTURE;
            axis_next  = 1'b0;
            state_next = S_ANG;
          end
        end
      end
      S_ANG: begin
        cmd.op     = tlu_pkg::OP_ANG_START;
        cnt_next   = CNT_W'(DIVW - 1);
        state_next = S_ADIV;
      end
      S_ADIV: begin
        cmd.op = tlu_pkg::OP_DIV_STEP;
        if (cnt == '0) begin
          state_next = S_CINIT;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      S_CINIT: begin
        cmd.op     = tlu_pkg::OP_CORDIC_INIT;
        cnt_next   = '0;
        state_next = S_CSTEP;
      end
      S_CSTEP: begin
        cmd.op = tlu_pkg::OP_CORDIC_STEP;
        if (cnt == CNT_W'(tlu_pkg::CORDIC_STEPS - 1)) begin
          state_next = S_CEND;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_CEND: begin
        cmd.op = tlu_pkg::OP_CORDIC_END;
        if (!axis) begin
          axis_next  = 1'b1;
          state_next = S_ANG;
        end else begin
          state_next = S_MULE;
        end
      end
      S_MULE: begin
        cmd.op     = tlu_pkg::OP_MUL_E;
        state_next = S_EXY;
      end
      S_EXY: begin
        cmd.op     = tlu_pkg::OP_EXY;
        k_next     = '0;
        state_next = S_LSTART;
      end
      S_LSTART: begin
        cmd.op     = tlu_pkg::OP_LAYER_START;
        s_next     = tlu_pkg::SET_MAIN;
        state_next = S_CLR;
      end
      S_CLR: begin
        cmd.op     = tlu_pkg::OP_ACC_CLR;
        j_next     = '0;
        state_next = S_RD;
      end
      S_RD: begin
        cmd.op     = tlu_pkg::OP_READ;
        cmd.idx    = {3'd0, j};
        state_next = (j == 2'd3) ? S_ACCD : S_MUL;
      end
      S_MUL: begin
        cmd.op     = tlu_pkg::OP_MUL_COEF;
        cmd.idx    = {3'd0, j};
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.op     = tlu_pkg::OP_ACC_PROD;
        j_next     = j + 2'd1;
        state_next = S_RD;
      end
      S_ACCD: begin
        cmd.op     = tlu_pkg::OP_ACC_D;
        state_next = S_SETV;
      end
      S_SETV: begin
        cmd.op = tlu_pkg::OP_SET_V;
        if (s == tlu_pkg::SET_MAIN) begin
          s_next     = tlu_pkg::SET_UPPER;
          state_next = S_CLR;
        end else if (s == tlu_pkg::SET_UPPER) begin
          if (k == 6'd0) begin
            state_next = S_DEN0;
          end else begin
            s_next     = tlu_pkg::SET_LOWER;
            state_next = S_CLR;
          end
        end else begin
          state_next = S_MLA;
        end
      end
      S_MLA: begin
        cmd.op     = tlu_pkg::OP_MUL_LA;
        state_next = S_LRE;
      end
      S_LRE: begin
        cmd.op     = tlu_pkg::OP_L_RE;
        state_next = S_MLB;
      end
      S_MLB: begin
        cmd.op     = tlu_pkg::OP_MUL_LB;
        state_next = S_LIM;
      end
      S_LIM: begin
        cmd.op     = tlu_pkg::OP_L_IM;
        state_next = S_MDA;
      end
      S_MDA: begin
        cmd.op     = tlu_pkg::OP_MUL_DA;
        state_next = S_DRE;
      end
      S_DRE: begin
        cmd.op     = tlu_pkg::OP_DEN_RE;
        state_next = S_MDB;
      end
      S_MDB: begin
        cmd.op     = tlu_pkg::OP_MUL_DB;
        state_next = S_DIM;
      end
      S_DIM: begin
        cmd.op     = tlu_pkg::OP_DEN_IM;
        state_next = S_MULN;
      end
      S_DEN0: begin
        cmd.op     = tlu_pkg::OP_DEN_D;
        state_next = S_MULN;
      end
      S_MULN: begin
        cmd.op     = tlu_pkg::OP_MUL_N;
        state_next = S_NORM;
      end
      S_NORM: begin
        cmd.op     = tlu_pkg::OP_NORM;
        state_next = S_RSTART;
      end
      S_RSTART: begin
        cmd.op     = tlu_pkg::OP_RECIP_START;
        cnt_next   = CNT_W'(DIVW - 1);
        state_next = stat.norm_zero ? S_EMIT : S_RDIV;
      end
      S_RDIV: begin
        cmd.op = tlu_pkg::OP_DIV_STEP;
        if (cnt == '0) begin
          state_next = S_REND;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      S_REND: begin
        cmd.op     = tlu_pkg::OP_RECIP_END;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.op = tlu_pkg::OP_EMIT;
          if (last_layer) begin
            state_next = S_IDLE;
          end else begin
            k_next     = k + 6'd1;
            state_next = S_LSTART;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= 1'b0;
      cnt   <= '0;
      k     <= '0;
      s     <= '0;
      j     <= '0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      cnt   <= cnt_next;
      k     <= k_next;
      s     <= s_next;
      j     <= j_next;
    end
  end

endmodule

// ----- src/tridiagonal_lu_eigen_columns.sv -----
// Load requests (mode 0) produce no result and leave the block ready for the next request.
// A factor request (mode 1) first evaluates the two cosine terms, then works through each
// layer in turn; DIVW = 32+2*FRAC_BITS is the divider width, 80 at the default.
// The reciprocal divider is serial and the coefficient memory has one shared read port.
// Reset (rst, synchronous, active high) clears control state and sizes to 1, 1, 64.
// The coefficient table is not cleared; entries read before being written are undefined.
module tridiagonal_lu_eigen_columns #(
  parameter int LAYERS_MAX = 64,
  parameter int FRAC_BITS  = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  tlu_item_if.sink    item,
  tlu_result_if.source result
);

  // Grid size registers. They must be written only while the block is idle; the block itself does not enforce this.
  logic [12:0] size_x;
  logic [12:0] size_y;
  logic [6:0]  size_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= 13'd1;
      size_y <= 13'd1;
      size_z <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        tlu_pkg::REG_SIZE_X: size_x <= cfg_data;
        tlu_pkg::REG_SIZE_Y: size_y <= cfg_data;
        tlu_pkg::REG_SIZE_Z: size_z <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  tlu_pkg::cmd_t  cmd;
  tlu_pkg::stat_t stat;

  // The controller sequences the cosine evaluation, the per-layer coefficient sums, the
  // recurrence products and the reciprocal division; each step is one datapath command.
  // A layer whose result register is still occupied waits in its emit step, so a
  // stalled receiver lengthens the column.
  tlu_ctrl #(
    .LAYERS_MAX(LAYERS_MAX),
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item.valid),
    .item_mode (item.mode),
    .item_ready(item.ready),
    .size_z    (size_z),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the coefficient memory, the multiplier pair, the shared divider,
  // the CORDIC unit and the output register, which lets the next layer proceed while a
  // result waits to be taken.
  tlu_datapath #(
    .LAYERS_MAX(LAYERS_MAX),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .size_x  (size_x),
    .size_y  (size_y),
    .ld_layer(item.layer),
    .ld_sel  (item.coef_sel),
    .ld_re   (item.value_re),
    .ld_im   (item.value_im),
    .col_x   (item.col_x),
    .col_y   (item.col_y),
    .result  (result)
  );

`ifndef SYNTHESIS
  // A factor request with a nonzero layer count keeps the block busy afterwards.
  assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready && item.mode && size_z != 7'd0) |=> !item.ready)
    else $error("block took a new request right after starting a column");

  // After a result that is not the last one, the column is still in progress.
  assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.ready && !result.last) |=> !item.ready)
    else $error("block went idle before the last layer of a column");

  // Results only appear while a column is in progress or just finished.
  assert property (@(posedge clk) disable iff (rst)
    (item.ready && !result.valid) |=> !(result.valid && !$past(result.valid) && item.ready
      && $past(item.ready)))
    else $error("result appeared while the block was idle");
`endif

endmodule

// ----- verif/tridiagonal_lu_eigen_columns_test.sv -----
module tridiagonal_lu_eigen_columns_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LAYERS = 64;
  localparam int SETS_PER_LAYER = 12;
  localparam int FRAC = 24;
  // Layers whose coefficients are written before any column is factored; no column in
  // this run uses more layers than this.
  localparam int FILL_LAYERS = 4;
  // Longest stretch without any accepted request or result before the run is abandoned.
  // A 64-layer column with heavy receiver stalls stays far below this.
  localparam int IDLE_LIMIT = 200000;
  // Cycles to wait after the last result before the block is treated as idle.
  localparam int SETTLE_CYCLES = 1000;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_FACTOR = 1'b1;

  typedef struct {
    logic               mode;
    logic [5:0]         layer;
    logic [3:0]         sel;
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [11:0]        x;
    logic [11:0]        y;
  } request_t;

  typedef struct {
    logic [5:0]         lyr;
    logic signed [31:0] l_re;
    logic signed [31:0] l_im;
    logic signed [31:0] u_re;
    logic signed [31:0] u_im;
    logic signed [31:0] p_re;
    logic signed [31:0] p_im;
    logic               sat;
    logic               last;
  } layer_result_t;

  typedef struct {
    request_t      req;
    logic          typed;
    layer_result_t want;
  } directed_row_t;

  typedef struct {
    longint re;
    longint im;
  } cplx_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [12:0] cfg_data;

  tlu_item_if item ();
  tlu_result_if result ();

  tridiagonal_lu_eigen_columns dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item(item.sink),
    .result(result.source)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Shadow state of the block: the coefficient store and the three size registers.
  longint unsigned coef_store[LAYERS * SETS_PER_LAYER];
  int unsigned grid_x;
  int unsigned grid_y;
  int unsigned layer_count;

  // Per-layer results still owed by the block, oldest first.
  layer_result_t owed_layers[$];
  int mismatches;
  int idle_cycles;
  int burst_left;

  function automatic longint clamp32(input longint v, inout bit f);
    if (v > 64'sd2147483647) begin
      f = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      f = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Fixed-point product, rounded half up.
  function automatic longint fx_mul(input longint a, input longint b);
    return (a * b + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
  endfunction

  // 2cos((idx+1)*pi/(size+1)) by folding into the first quadrant and running CORDIC.
  function automatic longint two_cos(input longint unsigned idx, input longint unsigned size,
                                     inout bit f);
    longint unsigned t;
    longint a;
    longint cx;
    longint cy;
    longint z;
    longint dx;
    longint dy;
    longint v;
    bit neg;
    t = ((idx + 1) << 30) / (size + 1);
    a = longint'(t & 64'h7fff_ffff);
    neg = 1'b0;
    if (a > 64'sd1073741824) a = 64'sd2147483648 - a;
    if (a > 64'sd536870912) begin
      a = 64'sd1073741824 - a;
      neg = 1'b1;
    end
    cx = 64'sd652032875;
    cy = 0;
    z = a;
    for (int i = 0; i < 28; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx = cx - dx;
        cy = cy + dy;
        z = z - longint'(tlu_pkg::cordic_angle(5'(i)));
      end else begin
        cx = cx + dx;
        cy = cy - dy;
        z = z + longint'(tlu_pkg::cordic_angle(5'(i)));
      end
    end
    v = (cx + 64'sd16) >>> 5;
    if (neg) v = -v;
    return clamp32(v, f);
  endfunction

  function automatic cplx_t coef_at(input int lyr, input int sel);
    cplx_t c;
    longint unsigned e;
    e = coef_store[lyr * SETS_PER_LAYER + sel];
    c.re = longint'($signed(e[31:0]));
    c.im = longint'($signed(e[63:32]));
    return c;
  endfunction

  // Diagonal value a*exy + b*ex + c*ey + d of one coefficient set.
  function automatic cplx_t diag_value(input int lyr, input int set, input longint ex,
                                       input longint ey, input longint exy, inout bit f);
    cplx_t a;
    cplx_t b;
    cplx_t c;
    cplx_t d;
    cplx_t r;
    a = coef_at(lyr, set * 4);
    b = coef_at(lyr, set * 4 + 1);
    c = coef_at(lyr, set * 4 + 2);
    d = coef_at(lyr, set * 4 + 3);
    r.re = clamp32(fx_mul(a.re, exy) + fx_mul(b.re, ex) + fx_mul(c.re, ey) + d.re, f);
    r.im = clamp32(fx_mul(a.im, exy) + fx_mul(b.im, ex) + fx_mul(c.im, ey) + d.im, f);
    return r;
  endfunction

  // One part of a reciprocal: num * 2^(2F) / n, truncated toward zero and saturated.
  function automatic longint recip_part(input longint num, input longint unsigned n,
                                        inout bit f);
    logic [127:0] mag;
    logic [127:0] q;
    mag = (num < 0) ? 128'(-num) : 128'(num);
    q = (mag << (2 * FRAC)) / 128'(n);
    if (num < 0) begin
      if (q > 128'h8000_0000) begin
        f = 1'b1;
        return -64'sd2147483648;
      end
      return -longint'(q[63:0]);
    end
    if (q > 128'h7fff_ffff) begin
      f = 1'b1;
      return 64'sd2147483647;
    end
    return longint'(q[63:0]);
  endfunction

  function automatic cplx_t reciprocal(input cplx_t d, inout bit f);
    longint unsigned n;
    cplx_t r;
    n = longint'(d.re * d.re) + longint'(d.im * d.im);
    if (n == 0) begin
      f = 1'b1;
      r.re = 64'sd2147483647;
      r.im = 0;
      return r;
    end
    r.re = recip_part(d.re, n, f);
    r.im = recip_part(-d.im, n, f);
    return r;
  endfunction

  // Updates the shadow store for a load, or queues the layer results of a factored column.
  task automatic predict_request(input request_t r);
    bit gsat;
    bit f;
    longint ex;
    longint ey;
    longint exy;
    int nz;
    cplx_t dv;
    cplx_t pv;
    cplx_t mv;
    cplx_t lv;
    cplx_t uv;
    cplx_t den;
    cplx_t u_prev;
    cplx_t p_prev;
    layer_result_t res;
    if (r.mode == MODE_LOAD) begin
      if (r.sel < SETS_PER_LAYER)
        coef_store[int'(r.layer) * SETS_PER_LAYER + int'(r.sel)] = {r.im, r.re};
      return;
    end
    nz = (layer_count > LAYERS) ? LAYERS : int'(layer_count);
    if (nz == 0) return;
    gsat = 1'b0;
    ex = two_cos(longint'(r.x), longint'(grid_x), gsat);
    ey = two_cos(longint'(r.y), longint'(grid_y), gsat);
    exy = clamp32(fx_mul(ex, ey), gsat);
    u_prev = '{0, 0};
    p_prev = '{0, 0};
    for (int k = 0; k < nz; k++) begin
      f = gsat;
      dv = diag_value(k, 0, ex, ey, exy, f);
      pv = diag_value(k, 1, ex, ey, exy, f);
      if (k == 0) begin
        lv = '{0, 0};
        uv = reciprocal(dv, f);
      end else begin
        mv = diag_value(k, 2, ex, ey, exy, f);
        lv.re = clamp32(fx_mul(mv.re, u_prev.re) - fx_mul(mv.im, u_prev.im), f);
        lv.im = clamp32(fx_mul(mv.re, u_prev.im) + fx_mul(mv.im, u_prev.re), f);
        den.re = clamp32(dv.re - (fx_mul(p_prev.re, lv.re) - fx_mul(p_prev.im, lv.im)), f);
        den.im = clamp32(dv.im - (fx_mul(p_prev.re, lv.im) + fx_mul(p_prev.im, lv.re)), f);
        uv = reciprocal(den, f);
      end
      res.lyr = 6'(k);
      res.l_re = 32'(lv.re);
      res.l_im = 32'(lv.im);
      res.u_re = 32'(uv.re);
      res.u_im = 32'(uv.im);
      res.p_re = 32'(pv.re);
      res.p_im = 32'(pv.im);
      res.sat = f;
      res.last = (k + 1 == nz);
      owed_layers.push_back(res);
      u_prev = uv;
      p_prev = pv;
    end
  endtask

  // Sizes are only changed while the block is idle, so the shadow copy updates at once.
  task automatic write_size(input logic [1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = 13'(value);
    @(posedge clk);
    if (idx == tlu_pkg::REG_SIZE_X) grid_x = value & 13'h1fff;
    else if (idx == tlu_pkg::REG_SIZE_Y) grid_y = value & 13'h1fff;
    else if (idx == tlu_pkg::REG_SIZE_Z) layer_count = value & 7'h7f;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Presents one request and holds it until the block takes it. The sender works in
  // bursts; at the end of a burst, in two of three cases, valid drops for a random number of cycles.
  task automatic send_request(input request_t r, output bit taken);
    @(negedge clk);
    item.valid = 1'b1;
    item.mode = r.mode;
    item.layer = r.layer;
    item.coef_sel = r.sel;
    item.value_re = r.re;
    item.value_im = r.im;
    item.col_x = r.x;
    item.col_y = r.y;
    do @(posedge clk); while (!(item.valid && item.ready));
    predict_request(r);
    taken = 1'b1;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 7);
      if ($urandom_range(0, 2) != 0) begin
        @(negedge clk);
        item.valid = 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end
    end
  endtask

  // Drops valid and waits until every owed result has come back, then lets the block settle.
  task automatic wait_idle();
    @(negedge clk);
    item.valid = 1'b0;
    while (owed_layers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic request_t random_request(input int factor_pct);
    request_t r;
    r.mode = ($urandom_range(0, 99) < factor_pct) ? MODE_FACTOR : MODE_LOAD;
    // Most loads go to the low layers, where short columns read them.
    r.layer = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
    r.sel = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 11));
    // Mostly modest magnitudes so that the recurrence stays meaningful, some full-range.
    if ($urandom_range(0, 3) == 0) begin
      r.re = $urandom;
      r.im = $urandom;
    end else begin
      r.re = $signed(32'($urandom)) >>> $urandom_range(4, 12);
      r.im = $signed(32'($urandom)) >>> $urandom_range(4, 12);
    end
    r.x = ($urandom_range(0, 1) == 0) ? 12'($urandom) : 12'($urandom_range(0, 15));
    r.y = ($urandom_range(0, 1) == 0) ? 12'($urandom) : 12'($urandom_range(0, 15));
    return r;
  endfunction

  // The receiver alternates run stretches and stall stretches of random length;
  // about a third of the stall stretches are empty, giving long stall-free runs.
  initial begin
    int run_left;
    int stall_left;
    run_left = 0;
    stall_left = 0;
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (run_left > 0) begin
        result.ready = 1'b1;
        run_left--;
      end else if (stall_left > 0) begin
        result.ready = 1'b0;
        stall_left--;
      end else begin
        run_left = $urandom_range(1, 40);
        stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        result.ready = 1'b1;
      end
    end
  end

  // Each accepted result is checked field by field against the oldest owed layer.
  always @(posedge clk) begin
    layer_result_t w;
    if (!rst && result.valid && result.ready) begin
      if (owed_layers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: layer %0d", result.out_layer);
      end else begin
        w = owed_layers.pop_front();
        if (result.out_layer !== w.lyr || result.lower_re !== w.l_re ||
            result.lower_im !== w.l_im || result.inv_pivot_re !== w.u_re ||
            result.inv_pivot_im !== w.u_im || result.upper_re !== w.p_re ||
            result.upper_im !== w.p_im || result.saturated !== w.sat ||
            result.last !== w.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected layer %0d L %0d,%0d U %0d,%0d Up %0d,%0d sat %0b last %0b",
                     w.lyr, w.l_re, w.l_im, w.u_re, w.u_im, w.p_re, w.p_im, w.sat, w.last);
            $display("          actual   layer %0d L %0d,%0d U %0d,%0d Up %0d,%0d sat %0b last %0b",
                     result.out_layer, result.lower_re, result.lower_im, result.inv_pivot_re,
                     result.inv_pivot_im, result.upper_re, result.upper_im, result.saturated,
                     result.last);
          end
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither a request nor a result is accepted.
  always @(posedge clk) begin
    if (rst || (item.valid && item.ready) || (result.valid && result.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[tridiagonal_lu_eigen_columns] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    directed_row_t rows[$];
    directed_row_t row;
    request_t r;
    layer_result_t zero_div;
    bit taken;
    int unsigned phase_sizes[5][3];
    int phase_items[5];
    int phase_pct[5];

    mismatches = 0;
    idle_cycles = 0;
    burst_left = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = tlu_pkg::REG_SIZE_X;
    cfg_data = '0;
    item.valid = 1'b0;
    item.mode = MODE_LOAD;
    item.layer = '0;
    item.coef_sel = '0;
    item.value_re = '0;
    item.value_im = '0;
    item.col_x = '0;
    item.col_y = '0;
    grid_x = 1;
    grid_y = 1;
    layer_count = 64;
    foreach (coef_store[i]) coef_store[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // The block does not clear its coefficient table, so every entry of the layers that
    // columns read is written once before any column is factored. Zero is the start.
    for (int i = 0; i < FILL_LAYERS * SETS_PER_LAYER; i++) begin
      r = '{MODE_LOAD, 6'(i / SETS_PER_LAYER), 4'(i % SETS_PER_LAYER), 0, 0, 0, 0};
      send_request(r, taken);
    end
    wait_idle();

    // Single-layer columns make the directed expectations easy to read.
    write_size(tlu_pkg::REG_SIZE_Z, 1);

    // With an all-zero main diagonal the first pivot divides by zero: U saturates to
    // +max, L is zero, Up is the all-zero upper value, and the layer is flagged.
    zero_div = '{6'd0, 0, 0, 32'sh7fffffff, 0, 0, 0, 1'b1, 1'b1};
    rows.push_back('{'{MODE_FACTOR, 6'd0, 4'd0, 0, 0, 12'd0, 12'd0}, 1'b1, zero_div});
    // A plain unit diagonal.
    rows.push_back('{'{MODE_LOAD, 6'd0, 4'd3, 32'sh0100_0000, 0, 0, 0}, 1'b0, zero_div});
    rows.push_back('{'{MODE_FACTOR, 6'd0, 4'd0, 0, 0, 12'd0, 12'd0}, 1'b0, zero_div});
    // Field extremes in the main and upper sets; selectors past the twelve sets must be ignored.
    rows.push_back('{'{MODE_LOAD, 6'd0, 4'd0, 32'sh7fffffff, 32'sh80000000, 0, 0}, 1'b0,
                     zero_div});
    rows.push_back('{'{MODE_LOAD, 6'd0, 4'd1, 32'sh80000000, 32'sh7fffffff, 0, 0}, 1'b0,
                     zero_div});
    rows.push_back('{'{MODE_LOAD, 6'd0, 4'd2, -32'sd1, -32'sd1, 0, 0}, 1'b0, zero_div});
    rows.push_back('{'{MODE_LOAD, 6'd0, 4'd12, 32'sh1234_5678, 32'sh0fed_cba9, 0, 0}, 1'b0,
                     zero_div});
    rows.push_back('{'{MODE_LOAD, 6'd63, 4'd15, -32'sd5, 32'sd7, 12'hfff, 12'hfff}, 1'b0,
                     zero_div});
    rows.push_back('{'{MODE_LOAD, 6'd0, 4'd4, 32'sh0080_0000, -32'sh0080_0000, 0, 0}, 1'b0,
                     zero_div});
    rows.push_back('{'{MODE_LOAD, 6'd0, 4'd7, 32'sh7fffffff, 32'sh7fffffff, 0, 0}, 1'b0,
                     zero_div});
    rows.push_back('{'{MODE_FACTOR, 6'd0, 4'd0, 0, 0, 12'd0, 12'd0}, 1'b0, zero_div});
    // Columns beyond the grid size wrap the angle.
    rows.push_back('{'{MODE_FACTOR, 6'd63, 4'd15, -1, -1, 12'hfff, 12'hfff}, 1'b0, zero_div});
    rows.push_back('{'{MODE_FACTOR, 6'd0, 4'd0, 0, 0, 12'd0, 12'hfff}, 1'b0, zero_div});
    rows.push_back('{'{MODE_LOAD, 6'd63, 4'd11, 32'sh80000000, 32'sh80000000, 0, 0}, 1'b0,
                     zero_div});
    rows.push_back('{'{MODE_LOAD, 6'd1, 4'd8, 32'sh0100_0000, 32'sh0040_0000, 0, 0}, 1'b0,
                     zero_div});
    rows.push_back('{'{MODE_LOAD, 6'd1, 4'd3, 32'sh0200_0000, 0, 0, 0}, 1'b0, zero_div});

    foreach (rows[i]) begin
      row = rows[i];
      send_request(row.req, taken);
      if (row.typed) begin
        void'(owed_layers.pop_back());
        owed_layers.push_back(row.want);
      end
    end
    wait_idle();

    // Random phases, each with its own grid sizes; grid sizes of 1 and 4096 are visited,
    // along with a zero layer count. Layer counts stay within the written layers.
    phase_sizes = '{'{7, 5, 4}, '{4096, 1, 1}, '{1, 4096, 0}, '{100, 4096, 2},
                    '{4096, 4096, 3}};
    phase_items = '{14, 10, 8, 14, 10};
    phase_pct = '{40, 30, 50, 40, 35};
    for (int p = 0; p < 5; p++) begin
      write_size(tlu_pkg::REG_SIZE_X, phase_sizes[p][0]);
      write_size(tlu_pkg::REG_SIZE_Y, phase_sizes[p][1]);
      write_size(tlu_pkg::REG_SIZE_Z, phase_sizes[p][2]);
      for (int n = 0; n < phase_items[p]; n++) begin
        r = random_request(phase_pct[p]);
        send_request(r, taken);
      end
      wait_idle();
    end

    if (mismatches == 0 && owed_layers.size() == 0) begin
      $display("[tridiagonal_lu_eigen_columns] OK");
    end else begin
      $display("[tridiagonal_lu_eigen_columns] ERROR");
    end
    $finish;
  end

endmodule
